// ===== design/tlrr_pkg.sv =====
package tlrr_pkg;

  localparam int LINE_BYTES  = 16;
  localparam int LINE_PIXELS = LINE_BYTES * 8;
  localparam int PIX_W       = $clog2(LINE_PIXELS);
  localparam int BYTE_CNT_W  = $clog2(LINE_BYTES);

  localparam int SMALL_CELL  = 6;
  localparam int SMALL_COLS  = 5;
  localparam int SMALL_ROWS  = 8;
  localparam int LARGE_CELL  = 18;
  localparam int LARGE_COLS  = 16;
  localparam int LARGE_ROWS  = 26;
  localparam int LARGE_FIRST = 32;
  localparam int LARGE_CELLS = LINE_PIXELS / LARGE_CELL;

  localparam int COL_W  = 5;
  localparam int CELL_W = 5;
  localparam int ROW_W  = 5;

  localparam logic [7:0] CMD_WRITE = 8'h80;
  localparam logic [7:0] PAD_BYTE  = 8'h00;

  typedef enum logic [2:0] {
    MODE_TEXT   = 3'd0,
    MODE_SMALL  = 3'd1,
    MODE_LARGE  = 3'd2,
    MODE_BEGIN  = 3'd3,
    MODE_RENDER = 3'd4,
    MODE_END    = 3'd5
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] index;
    logic [15:0] value;
    logic [7:0]  row_address;
    logic        large_font;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       msb_first;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic             start;
    logic             run;
    logic             adv;
    logic             lg_font;
    logic [ROW_W-1:0] row;
  } fetch_ctrl_t;

  typedef struct packed {
    logic valid;
    logic white;
  } pix_t;

endpackage

// ===== design/tlrr_fetch.sv =====
module tlrr_fetch import tlrr_pkg::*; #(
  parameter int TEXT_DEPTH       = 32,
  parameter int SMALL_FONT_CHARS = 256,
  parameter int LARGE_FONT_CHARS = 96
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ld_i,
  input  in_req_t     ld_req_i,
  input  fetch_ctrl_t ctrl_i,
  output pix_t        pix_o
);

  localparam int SmallDepth = SMALL_FONT_CHARS * SMALL_CELL;
  localparam int LargeDepth = LARGE_FONT_CHARS * LARGE_ROWS;
  localparam int TextAw     = $clog2(TEXT_DEPTH);
  localparam int SmallAw    = $clog2(SmallDepth);
  localparam int LargeAw    = $clog2(LargeDepth);

  logic [7:0]            text_mem  [TEXT_DEPTH];
  logic [7:0]            small_mem [SmallDepth];
  logic [15:0]           large_mem [LargeDepth];
  logic [TEXT_DEPTH-1:0] text_vld_q;

  logic [12:0]        idx_w;
  logic               text_we, small_we, large_we;
  logic [TextAw-1:0]  text_waddr, text_raddr;

  logic [PIX_W-1:0]  pix_q;
  logic              done_q;
  logic [COL_W-1:0]  col_q;
  logic [CELL_W-1:0] cell_q;
  logic              a_valid, a_step, a_white, col_last;

  logic              b_valid_q, b_white_q;
  logic [COL_W-1:0]  b_col_q;
  logic [7:0]        text_rd_q;
  logic              text_hit_q;
  logic [7:0]        code, lg_off;
  logic              sm_ok, lg_ok, b_white;
  logic [10:0]       sm_addr_w;
  logic [12:0]       lg_addr_w;

  logic              c_valid_q, c_white_q;
  logic [3:0]        c_col_q;
  logic [7:0]        sm_rd_q;
  logic [15:0]       lg_rd_q;

  assign idx_w      = {1'b0, ld_req_i.index};
  assign text_we    = ld_i && (ld_req_i.mode == MODE_TEXT) && (idx_w < 13'(TEXT_DEPTH));
  assign small_we   = ld_i && (ld_req_i.mode == MODE_SMALL) && (idx_w < 13'(SmallDepth));
  assign large_we   = ld_i && (ld_req_i.mode == MODE_LARGE) && (idx_w < 13'(LargeDepth));
  assign text_waddr = TextAw'(ld_req_i.index);
  assign text_raddr = TextAw'(cell_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_vld_q <= '0;
    end else if (text_we) begin
      text_vld_q[text_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= ld_req_i.value[7:0];
    end
    if (ctrl_i.adv) begin
      text_rd_q  <= text_mem[text_raddr];
      text_hit_q <= text_vld_q[text_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (small_we) begin
      small_mem[SmallAw'(ld_req_i.index)] <= ld_req_i.value[7:0];
    end
    if (ctrl_i.adv) begin
      sm_rd_q <= small_mem[SmallAw'(sm_addr_w)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (large_we) begin
      large_mem[LargeAw'(ld_req_i.index)] <= ld_req_i.value;
    end
    if (ctrl_i.adv) begin
      lg_rd_q <= large_mem[LargeAw'(lg_addr_w)];
    end
  end

  // Pixel walk: one pixel per step, tracking its cell and column.
  assign a_valid  = ctrl_i.run && !done_q;
  assign a_step   = a_valid && ctrl_i.adv;
  assign col_last = ctrl_i.lg_font ? (col_q == COL_W'(LARGE_CELL - 1))
                                   : (col_q == COL_W'(SMALL_CELL - 1));
  assign a_white  = !({2'b00, cell_q} < 7'(TEXT_DEPTH)) ||
                    (ctrl_i.lg_font ? ((col_q >= COL_W'(LARGE_COLS)) ||
                                       (cell_q >= CELL_W'(LARGE_CELLS)))
                                    : (col_q >= COL_W'(SMALL_COLS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q  <= '0;
      done_q <= 1'b0;
      col_q  <= '0;
      cell_q <= '0;
    end else if (ctrl_i.start) begin
      pix_q  <= '0;
      done_q <= 1'b0;
      col_q  <= '0;
      cell_q <= '0;
    end else if (a_step) begin
      pix_q <= pix_q + 1'b1;
      if (pix_q == PIX_W'(LINE_PIXELS - 1)) begin
        done_q <= 1'b1;
      end
      if (col_last) begin
        col_q  <= '0;
        cell_q <= cell_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Character code is known here; form the glyph address.
  assign code      = text_hit_q ? text_rd_q : 8'h00;
  assign lg_off    = code - 8'(LARGE_FIRST);
  assign sm_ok     = {1'b0, code} < 9'(SMALL_FONT_CHARS);
  assign lg_ok     = (code >= 8'(LARGE_FIRST)) && ({1'b0, lg_off} < 9'(LARGE_FONT_CHARS));
  assign sm_addr_w = 11'(code) * 11'(SMALL_CELL) + 11'(b_col_q);
  assign lg_addr_w = 13'(lg_off) * 13'(LARGE_ROWS) + 13'(ctrl_i.row);
  assign b_white   = b_white_q || (ctrl_i.lg_font ? !lg_ok : !sm_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      b_valid_q <= a_valid;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      b_col_q   <= col_q;
      b_white_q <= a_white;
      c_col_q   <= b_col_q[3:0];
      c_white_q <= b_white;
    end
  end

  // Large glyph words are MSB first, so column k reads bit 15-k.
  assign pix_o.valid = c_valid_q;
  assign pix_o.white = c_white_q ||
                       (ctrl_i.lg_font ? !lg_rd_q[~c_col_q] : !sm_rd_q[ctrl_i.row[2:0]]);

endmodule

// ===== design/tlrr_pack.sv =====
module tlrr_pack import tlrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  pix_t       pix_i,
  output logic       emit_o,
  output logic [7:0] line_byte_o,
  output logic       line_end_o
);

  logic [7:0]            sh_q;
  logic [2:0]            bit_q;
  logic [BYTE_CNT_W-1:0] byte_cnt_q;

  // Pixels enter at the top, so the first one ends at bit 0.
  assign line_byte_o = {pix_i.white, sh_q[7:1]};
  assign emit_o      = pix_i.valid && (bit_q == 3'd7);
  assign line_end_o  = emit_o && (byte_cnt_q == BYTE_CNT_W'(LINE_BYTES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q      <= '0;
      byte_cnt_q <= '0;
    end else if (adv_i && pix_i.valid) begin
      bit_q <= bit_q + 1'b1;
      if (emit_o) begin
        byte_cnt_q <= byte_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && pix_i.valid) begin
      sh_q <= line_byte_o;
    end
  end

endmodule

// ===== design/text_line_raster_renderer_unit.sv =====
// Load requests are written to their store as they are accepted; begin and end requests
// pass their byte through the header state to the output register once it is free.
// A render request walks the 128 line pixels one per cycle, unless the output stalls,
// through a three-stage fetch (text read, glyph read, bit select) into a byte shift register.
// Reset clears the control state and the text buffer; the glyph stores are not cleared.
module text_line_raster_renderer_unit import tlrr_pkg::*; #(
  parameter int TEXT_DEPTH       = 32,
  parameter int SMALL_FONT_CHARS = 256,
  parameter int LARGE_FONT_CHARS = 96
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_PIX  = 4'b0100,
    S_PAD  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  out_req_t         hdr_q, hdr_d;
  logic             render_q, render_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             large_q, large_d;
  logic             out_valid_q, out_valid_d;
  out_req_t         out_q, out_d;

  logic        accept, row_ok, out_free, adv, start;
  logic        emit, line_end;
  logic [7:0]  line_byte;
  fetch_ctrl_t ctrl;
  pix_t        pix;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign row_ok      = in_req_i.large_font ? (in_req_i.index < 12'(LARGE_ROWS))
                                           : (in_req_i.index < 12'(SMALL_ROWS));
  assign start       = accept && (in_req_i.mode == MODE_RENDER) && row_ok;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = !(emit && !out_free);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  assign ctrl = '{start: start, run: (state_q == S_PIX), adv: adv,
                  lg_font: large_q, row: row_q};

  tlrr_fetch #(
    .TEXT_DEPTH      (TEXT_DEPTH),
    .SMALL_FONT_CHARS(SMALL_FONT_CHARS),
    .LARGE_FONT_CHARS(LARGE_FONT_CHARS)
  ) u_fetch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (accept),
    .ld_req_i(in_req_i),
    .ctrl_i  (ctrl),
    .pix_o   (pix)
  );

  tlrr_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .pix_i      (pix),
    .emit_o     (emit),
    .line_byte_o(line_byte),
    .line_end_o (line_end)
  );

  always_comb begin
    state_d     = state_q;
    hdr_d       = hdr_q;
    render_d    = render_q;
    row_d       = row_q;
    large_d     = large_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_e'(in_req_i.mode))
            MODE_BEGIN: begin
              hdr_d    = '{out_byte: CMD_WRITE, msb_first: 1'b1, last: 1'b1};
              render_d = 1'b0;
              state_d  = S_HEAD;
            end
            MODE_END: begin
              hdr_d    = '{out_byte: PAD_BYTE, msb_first: 1'b0, last: 1'b1};
              render_d = 1'b0;
              state_d  = S_HEAD;
            end
            MODE_RENDER: begin
              if (row_ok) begin
                hdr_d    = '{out_byte: in_req_i.row_address + in_req_i.index[7:0],
                             msb_first: 1'b0, last: 1'b0};
                render_d = 1'b1;
                row_d    = in_req_i.index[ROW_W-1:0];
                large_d  = in_req_i.large_font;
                state_d  = S_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HEAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = hdr_q;
          state_d     = render_q ? S_PIX : S_IDLE;
        end
      end
      S_PIX: begin
        if (emit && out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: line_byte, msb_first: 1'b0, last: 1'b0};
          if (line_end) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: PAD_BYTE, msb_first: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      render_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      render_q    <= render_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q   <= hdr_d;
    row_q   <= row_d;
    large_q <= large_d;
    out_q   <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid |-> (state_q == S_PIX))
    else $error("pixel pipeline active outside line rendering");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> (out_valid_q && out_stall_i))
    else $error("pixel pipeline held while output register can take a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.msb_first) |-> out_q.last)
    else $error("command byte not marked as last of its request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == S_HEAD) && render_q)
    else $error("render request did not start a line");

endmodule
